### sv/mrf_pkg.sv
// Package: shared types and constants for the mono raster fill unit.
package mrf_pkg;

   localparam int PanelWidth  = 200;
   localparam int PanelHeight = 200;
   localparam int StoreBytes  = 5000;
   localparam int RowBytes    = (PanelWidth + 7) / 8;
   localparam int AddrW       = 13;
   localparam int CoordW      = 12;

   typedef enum logic [2:0] {
      MODE_PIXEL = 3'd0,
      MODE_HLINE = 3'd1,
      MODE_VLINE = 3'd2,
      MODE_RECT  = 3'd3,
      MODE_FIND  = 3'd4,
      MODE_CLEAR = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      OP_FILL  = 2'd0,
      OP_FIND  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Classified command handed from front to back.
   typedef struct packed {
      op_type            op;
      logic              ink;
      logic [8:0]        x0;     // first physical column
      logic [8:0]        x1;     // last physical column
      logic [8:0]        y0;     // first physical row
      logic [8:0]        y1;     // last physical row
      logic [AddrW-1:0]  from;
   } cmd_type;

   typedef struct packed {
      logic [AddrW-1:0] changed_count;
      logic             run_found;
      logic [AddrW-1:0] run_start;
      logic [AddrW-1:0] run_length;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_FIND,
      ST_CLEAR,
      ST_DONE
   } state_type;

endpackage

### sv/mrf_req_if.sv
// Interface: request channel carrying one drawing or dirty-map command.
interface mrf_req_if;
   logic             valid;
   logic             ready;
   logic [2:0]       mode;
   logic signed [9:0] x_pos;
   logic signed [9:0] y_pos;
   logic signed [9:0] span_x;
   logic signed [9:0] span_y;
   logic             ink;
   logic [12:0]      run_from;
   modport source (output valid, mode, x_pos, y_pos, span_x, span_y, ink, run_from,
                   input ready);
   modport sink   (input valid, mode, x_pos, y_pos, span_x, span_y, ink, run_from,
                   output ready);
endinterface

// Interface: response channel carrying one command result.
interface mrf_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] changed_count;
   logic        run_found;
   logic [12:0] run_start;
   logic [12:0] run_length;
   modport source (output valid, changed_count, run_found, run_start, run_length,
                   input ready);
   modport sink   (input valid, changed_count, run_found, run_start, run_length,
                   output ready);
endinterface

### sv/mrf_front.sv
// Front end: normalize, clip and rotate commands into physical rectangles.
module mrf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_wdata,
   mrf_req_if.sink               req,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output mrf_pkg::cmd_type      cmd
);

   logic [1:0] rotation_ff;
   logic signed [mrf_pkg::CoordW-1:0] x, y, w, h, lw, lh, xa, ya, wa, ha;
   logic signed [mrf_pkg::CoordW-1:0] px, py, pw, ph;
   logic        empty;
   mrf_pkg::op_type op;
   mrf_pkg::cmd_type cmd_ff, cmd_in;
   logic cmd_valid_ff, cmd_valid_in;

   // Hold rotation register.
   always_ff @(posedge clock) begin
      if (reset) rotation_ff <= 2'd0;
      else if (csr_we) rotation_ff <= csr_wdata;
   end

   // Classify and clip.
   always_comb begin
      x = mrf_pkg::CoordW'(req.x_pos);
      y = mrf_pkg::CoordW'(req.y_pos);
      w = 12'sd1;
      h = 12'sd1;
      op = mrf_pkg::OP_NONE;
      unique case (req.mode)
         mrf_pkg::MODE_PIXEL: op = mrf_pkg::OP_FILL;
         mrf_pkg::MODE_HLINE: begin
            op = mrf_pkg::OP_FILL; w = mrf_pkg::CoordW'(req.span_x);
         end
         mrf_pkg::MODE_VLINE: begin
            op = mrf_pkg::OP_FILL; h = mrf_pkg::CoordW'(req.span_y);
         end
         mrf_pkg::MODE_RECT: begin
            op = mrf_pkg::OP_FILL;
            w = mrf_pkg::CoordW'(req.span_x);
            h = mrf_pkg::CoordW'(req.span_y);
         end
         mrf_pkg::MODE_FIND:  op = mrf_pkg::OP_FIND;
         mrf_pkg::MODE_CLEAR: op = mrf_pkg::OP_CLEAR;
         default:             op = mrf_pkg::OP_NONE;
      endcase
      lw = rotation_ff[0] ? 12'(mrf_pkg::PanelHeight) : 12'(mrf_pkg::PanelWidth);
      lh = rotation_ff[0] ? 12'(mrf_pkg::PanelWidth) : 12'(mrf_pkg::PanelHeight);
      xa = x; wa = w; ya = y; ha = h;
      if (wa < 0) begin wa = -wa; xa = xa - wa + 12'sd1; end
      if (ha < 0) begin ha = -ha; ya = ya - ha + 12'sd1; end
      if (xa < 0) begin wa = wa + xa; xa = '0; end
      if (ya < 0) begin ha = ha + ya; ya = '0; end
      if (xa + wa > lw) wa = lw - xa;
      if (ya + ha > lh) ha = lh - ya;
      empty = (wa <= 0) || (ha <= 0);
      px = xa; py = ya; pw = wa; ph = ha;
      case (rotation_ff)
         2'd1: begin
            px = 12'(mrf_pkg::PanelWidth) - ya - ha; py = xa; pw = ha; ph = wa;
         end
         2'd2: begin
            px = 12'(mrf_pkg::PanelWidth) - xa - wa;
            py = 12'(mrf_pkg::PanelHeight) - ya - ha;
         end
         2'd3: begin
            px = ya; py = 12'(mrf_pkg::PanelHeight) - xa - wa; pw = ha; ph = wa;
         end
         default: ;
      endcase
      if (op == mrf_pkg::OP_FILL && empty) op = mrf_pkg::OP_NONE;
      cmd_in.op   = op;
      cmd_in.ink  = req.ink;
      cmd_in.x0   = px[8:0];
      cmd_in.x1   = 9'(px + pw - 12'sd1);
      cmd_in.y0   = py[8:0];
      cmd_in.y1   = 9'(py + ph - 12'sd1);
      cmd_in.from = req.run_from;
   end

   // One-entry queue stage toward the back end.
   assign req.ready = !cmd_valid_ff || cmd_ready;
   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      if (cmd_ready) cmd_valid_in = 1'b0;
      if (req.valid && req.ready) cmd_valid_in = 1'b1;
   end
   always_ff @(posedge clock) begin
      if (reset) cmd_valid_ff <= 1'b0;
      else cmd_valid_ff <= cmd_valid_in;
      if (req.valid && req.ready) cmd_ff <= cmd_in;
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd = cmd_ff;

   a_cmd_hold: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
      else $error("queued command changed while stalled");
   a_no_fill_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd.op == mrf_pkg::OP_FILL |-> cmd.x0 <= cmd.x1 && cmd.y0 <= cmd.y1)
      else $error("fill with empty extent");
   a_rot_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_we |=> $stable(rotation_ff))
      else $error("rotation changed without write");
endmodule

### sv/mrf_back.sv
// Back end: byte read-modify-write, dirty run search and dirty clear.
module mrf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  mrf_pkg::cmd_type  cmd,
   output logic              res_valid,
   input  logic              res_ready,
   output mrf_pkg::rsp_type  res
);
   localparam int AW = mrf_pkg::AddrW;

   logic [7:0] fb_mem [mrf_pkg::StoreBytes];
   logic       dm_mem [mrf_pkg::StoreBytes];

   mrf_pkg::state_type state_ff, state_in;
   mrf_pkg::cmd_type   c_ff;
   logic [AW-1:0] addr_ff, addr_in, rd_addr;
   logic [8:0]    row_ff, row_in;
   logic [5:0]    col_ff, col_in;
   logic [7:0]    fb_q_ff;
   logic          dm_q_ff;
   logic [AW-1:0] cnt_ff, cnt_in, start_ff, start_in, len_ff, len_in;
   logic          found_ff, found_in, prev_rd_ff;
   logic          fb_we, dm_we, dm_wd;
   logic [AW-1:0] fb_wa, dm_wa;
   logic [7:0]    fb_wd, mask, nv;
   logic [AW+1:0] lin;
   logic          res_valid_ff, res_valid_in;
   logic          last_col, last_row;

   // Byte mask for the current column.
   always_comb begin
      logic [7:0] lo, hi;
      lo = (col_ff == c_ff.x0[8:3]) ? (8'hFF >> c_ff.x0[2:0]) : 8'hFF;
      hi = (col_ff == c_ff.x1[8:3]) ? (8'hFF << (3'd7 - c_ff.x1[2:0])) : 8'hFF;
      mask = lo & hi;
      nv = c_ff.ink ? (fb_q_ff | mask) : (fb_q_ff & ~mask);
      lin = (AW+2)'(row_ff) * (AW+2)'(mrf_pkg::RowBytes) + (AW+2)'(col_ff);
   end
   assign last_col = (col_ff == c_ff.x1[8:3]);
   assign last_row = (row_ff == c_ff.y1);

   // Next state and counters.
   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff; row_in = row_ff; col_in = col_ff;
      cnt_in = cnt_ff; start_in = start_ff; len_in = len_ff; found_in = found_ff;
      unique case (state_ff)
         mrf_pkg::ST_INIT: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == AW'(mrf_pkg::StoreBytes - 1)) state_in = mrf_pkg::ST_IDLE;
         end
         mrf_pkg::ST_IDLE: if (cmd_valid) begin
            cnt_in = '0; start_in = '0; len_in = '0; found_in = 1'b0;
            row_in = cmd.y0; col_in = cmd.x0[8:3]; addr_in = cmd.from;
            case (cmd.op)
               mrf_pkg::OP_FILL:  state_in = mrf_pkg::ST_FILL_RD;
               mrf_pkg::OP_FIND:  state_in = (cmd.from >= AW'(mrf_pkg::StoreBytes)) ?
                                             mrf_pkg::ST_DONE : mrf_pkg::ST_FIND;
               mrf_pkg::OP_CLEAR: begin addr_in = '0; state_in = mrf_pkg::ST_CLEAR; end
               default:           state_in = mrf_pkg::ST_DONE;
            endcase
         end
         mrf_pkg::ST_FILL_RD: state_in = mrf_pkg::ST_FILL_WR;
         mrf_pkg::ST_FILL_WR: begin
            if (lin < (AW+2)'(mrf_pkg::StoreBytes) && nv != fb_q_ff) cnt_in = cnt_ff + 1'b1;
            state_in = mrf_pkg::ST_FILL_RD;
            if (last_col) begin
               col_in = c_ff.x0[8:3]; row_in = row_ff + 1'b1;
               if (last_row) state_in = mrf_pkg::ST_DONE;
            end else col_in = col_ff + 1'b1;
         end
         mrf_pkg::ST_FIND: begin
            // read of addr_ff-1 is in dm_q_ff when prev_rd_ff
            if (prev_rd_ff) begin
               if (dm_q_ff) begin
                  if (!found_ff) begin found_in = 1'b1; start_in = addr_ff - 1'b1; end
                  len_in = len_ff + 1'b1;
               end else if (found_ff) state_in = mrf_pkg::ST_DONE;
            end
            if (state_in == mrf_pkg::ST_FIND) begin
               if (addr_ff == AW'(mrf_pkg::StoreBytes)) state_in = mrf_pkg::ST_DONE;
               else addr_in = addr_ff + 1'b1;
            end
         end
         mrf_pkg::ST_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == AW'(mrf_pkg::StoreBytes - 1)) state_in = mrf_pkg::ST_DONE;
         end
         mrf_pkg::ST_DONE: if (!res_valid_ff || res_ready) state_in = mrf_pkg::ST_IDLE;
         default: state_in = mrf_pkg::ST_IDLE;
      endcase
   end

   // Memory port controls.
   always_comb begin
      fb_we = 1'b0; dm_we = 1'b0; dm_wd = 1'b0;
      fb_wa = lin[AW-1:0]; dm_wa = lin[AW-1:0]; fb_wd = nv;
      rd_addr = (state_ff == mrf_pkg::ST_FIND) ? addr_ff : lin[AW-1:0];
      unique case (state_ff)
         mrf_pkg::ST_INIT: begin
            fb_we = 1'b1; dm_we = 1'b1; fb_wa = addr_ff; dm_wa = addr_ff; fb_wd = '0;
         end
         mrf_pkg::ST_FILL_WR:
            if (lin < (AW+2)'(mrf_pkg::StoreBytes) && nv != fb_q_ff) begin
               fb_we = 1'b1; dm_we = 1'b1; dm_wd = 1'b1;
            end
         mrf_pkg::ST_CLEAR: begin dm_we = 1'b1; dm_wa = addr_ff; end
         default: ;
      endcase
   end

   // Frame and dirty stores.
   always_ff @(posedge clock) begin
      if (fb_we) fb_mem[fb_wa] <= fb_wd;
      if (dm_we) dm_mem[dm_wa] <= dm_wd;
      if (rd_addr < AW'(mrf_pkg::StoreBytes)) begin
         fb_q_ff <= fb_mem[rd_addr];
         dm_q_ff <= dm_mem[rd_addr];
      end else begin
         fb_q_ff <= '0;
         dm_q_ff <= 1'b0;
      end
   end

   // Drop the result once taken, raise it when a command finishes.
   always_comb begin
      res_valid_in = res_valid_ff;
      if (res_ready) res_valid_in = 1'b0;
      if (state_ff == mrf_pkg::ST_DONE && (!res_valid_ff || res_ready)) res_valid_in = 1'b1;
   end

   // Hold control state and result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrf_pkg::ST_INIT;
         addr_ff <= '0;
         res_valid_ff <= 1'b0;
         prev_rd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         prev_rd_ff <= (state_ff == mrf_pkg::ST_FIND);
         res_valid_ff <= res_valid_in;
         if (state_ff == mrf_pkg::ST_DONE && (!res_valid_ff || res_ready)) begin
            res.changed_count <= (c_ff.op == mrf_pkg::OP_FILL) ? cnt_ff : '0;
            res.run_found  <= found_ff;
            res.run_start  <= start_ff;
            res.run_length <= len_ff;
         end
      end
      if (state_ff == mrf_pkg::ST_IDLE && cmd_valid) c_ff <= cmd;
      row_ff <= row_in; col_ff <= col_in;
      cnt_ff <= cnt_in; start_ff <= start_in; len_ff <= len_in; found_ff <= found_in;
   end

   assign cmd_ready = (state_ff == mrf_pkg::ST_IDLE);
   assign res_valid = res_valid_ff;

   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid && $stable(res))
      else $error("result changed while stalled");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> state_ff == mrf_pkg::ST_IDLE)
      else $error("command taken while busy");
   a_len_found: assert property (@(posedge clock) disable iff (reset)
      !found_ff && state_ff == mrf_pkg::ST_FIND |-> len_ff == '0)
      else $error("run length without a run");
endmodule

### sv/mono_raster_fill_with_dirty_runs_unit.sv
// Top level: mono raster fill unit with dirty-run tracking.
//  channel | dir | payload
//  req     | in  | mode, x_pos, y_pos, span_x, span_y, ink, run_from
//  rsp     | out | changed_count, run_found, run_start, run_length
//  csr     | in  | rotation (2 bits)
// A fill reads and then rewrites each covered byte in turn (byte read-modify-write).
// Find-run checks one dirty bit per cycle; clear resets every dirty bit in turn.
// After reset a clearing pass over all 5000 bytes of both stores runs before the first command is taken.
// A one-deep queue lets the front take the next command while the back is busy.
module mono_raster_fill_with_dirty_runs_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   mrf_req_if.sink     req,
   mrf_rsp_if.source   rsp
);
   logic             cmd_valid, cmd_ready;
   mrf_pkg::cmd_type cmd;
   mrf_pkg::rsp_type res;

   mrf_front u_front (.clock, .reset, .csr_we, .csr_wdata, .req,
                      .cmd_valid, .cmd_ready, .cmd);
   mrf_back u_back (.clock, .reset, .cmd_valid, .cmd_ready, .cmd,
                    .res_valid(rsp.valid), .res_ready(rsp.ready), .res);

   // Drive response payload.
   assign rsp.changed_count = res.changed_count;
   assign rsp.run_found     = res.run_found;
   assign rsp.run_start     = res.run_start;
   assign rsp.run_length    = res.run_length;
endmodule

### dv/tb_top.sv
// Testbench for the mono raster fill unit: directed table, then random commands per rotation.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam int         CYCLE_LIMIT   = 40000000;
   localparam int         DRAIN_CYCLES  = 40;

   typedef struct {
      logic [2:0]        mode;
      logic signed [9:0] x_pos;
      logic signed [9:0] y_pos;
      logic signed [9:0] span_x;
      logic signed [9:0] span_y;
      logic              ink;
      logic [12:0]       run_from;
      bit                has_gold;
      mrf_pkg::rsp_type  gold;
   } cmd_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [1:0] csr_wdata;

   mrf_req_if req_ch();
   mrf_rsp_if rsp_ch();

   mono_raster_fill_with_dirty_runs_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   // Shadow framebuffer, dirty map and rotation
   bit [7:0] shadow_fb [mrf_pkg::StoreBytes];
   bit       shadow_dirty [mrf_pkg::StoreBytes];
   bit [1:0] shadow_rot;

   mrf_pkg::rsp_type pending_rsp[$];
   int       mismatches;
   int       cycle_count;
   int       rsp_seen;
   int       mode_hits [8];
   int       burst_left;
   bit [3:0] rot_seen;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Print one mismatch line and count it
   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch #%0d at cycle %0d: %s got %0d want %0d",
               mismatches + 1, cycle_count, what, got, want);
      mismatches++;
   endtask

   // Fill a logical rectangle into the shadow store; return changed byte count
   function automatic int paint_rect(int x, int y, int w, int h, bit ink);
      int lw, lh, t, row, b, s, e, last, idx, changed;
      bit [7:0] mask, nv;
      lw = shadow_rot[0] ? mrf_pkg::PanelHeight : mrf_pkg::PanelWidth;
      lh = shadow_rot[0] ? mrf_pkg::PanelWidth : mrf_pkg::PanelHeight;
      changed = 0;
      if (w < 0) begin
         w = -w;
         x = x - w + 1;
      end
      if (h < 0) begin
         h = -h;
         y = y - h + 1;
      end
      if (x < 0) begin
         w += x;
         x = 0;
      end
      if (y < 0) begin
         h += y;
         y = 0;
      end
      if (x + w > lw) w = lw - x;
      if (y + h > lh) h = lh - y;
      if (w <= 0 || h <= 0) return 0;
      // Map logical rectangle onto the panel
      case (shadow_rot)
         2'd1: begin
            t = x; x = y; y = t;
            t = w; w = h; h = t;
            x = mrf_pkg::PanelWidth - x - w;
         end
         2'd2: begin
            x = mrf_pkg::PanelWidth - x - w;
            y = mrf_pkg::PanelHeight - y - h;
         end
         2'd3: begin
            t = x; x = y; y = t;
            t = w; w = h; h = t;
            y = mrf_pkg::PanelHeight - y - h;
         end
         default: ;
      endcase
      last = x + w - 1;
      for (row = y; row < y + h; row++) begin
         for (b = x >> 3; b <= (last >> 3); b++) begin
            s = (x > b * 8) ? x : b * 8;
            e = (last < b * 8 + 7) ? last : b * 8 + 7;
            mask = (8'hFF >> (s & 7)) & (8'hFF << (7 - (e & 7)));
            idx = b + row * mrf_pkg::RowBytes;
            if (idx < mrf_pkg::StoreBytes) begin
               nv = ink ? (shadow_fb[idx] | mask) : (shadow_fb[idx] & ~mask);
               if (nv != shadow_fb[idx]) begin
                  shadow_fb[idx] = nv;
                  shadow_dirty[idx] = 1'b1;
                  changed++;
               end
            end
         end
      end
      return (changed > mrf_pkg::StoreBytes) ? mrf_pkg::StoreBytes : changed;
   endfunction

   // Apply one command to the shadow state and return its response
   function automatic mrf_pkg::rsp_type predict_rsp(cmd_row_type c);
      mrf_pkg::rsp_type r;
      int i, st;
      r = '0;
      case (c.mode)
         mrf_pkg::MODE_PIXEL:
            r.changed_count = 13'(paint_rect(c.x_pos, c.y_pos, 1, 1, c.ink));
         mrf_pkg::MODE_HLINE:
            r.changed_count = 13'(paint_rect(c.x_pos, c.y_pos, c.span_x, 1, c.ink));
         mrf_pkg::MODE_VLINE:
            r.changed_count = 13'(paint_rect(c.x_pos, c.y_pos, 1, c.span_y, c.ink));
         mrf_pkg::MODE_RECT:
            r.changed_count = 13'(paint_rect(c.x_pos, c.y_pos, c.span_x, c.span_y,
                                             c.ink));
         mrf_pkg::MODE_FIND: begin
            i = c.run_from;
            while (i < mrf_pkg::StoreBytes && !shadow_dirty[i]) i++;
            if (i < mrf_pkg::StoreBytes) begin
               st = i;
               while (i < mrf_pkg::StoreBytes && shadow_dirty[i]) i++;
               r.run_found  = 1'b1;
               r.run_start  = 13'(st);
               r.run_length = 13'(i - st);
            end
         end
         mrf_pkg::MODE_CLEAR: foreach (shadow_dirty[k]) shadow_dirty[k] = 1'b0;
         default: ;
      endcase
      return r;
   endfunction

   // Drive one command transaction, holding until accepted
   task automatic send_cmd(cmd_row_type c);
      bit took;
      mrf_pkg::rsp_type want;
      // Sender bursts with random gaps between them
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= c.mode;
      req_ch.x_pos    <= c.x_pos;
      req_ch.y_pos    <= c.y_pos;
      req_ch.span_x   <= c.span_x;
      req_ch.span_y   <= c.span_y;
      req_ch.ink      <= c.ink;
      req_ch.run_from <= c.run_from;
      do begin
         @(negedge clock);
         took = req_ch.ready;
         @(posedge clock);
      end while (!took);
      want = predict_rsp(c);
      if (c.has_gold) want = c.gold;
      pending_rsp.push_back(want);
      mode_hits[c.mode]++;
   endtask

   // Drop valid and hold until every response is back
   task automatic drain_pending();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_rotation(bit [1:0] rot);
      drain_pending();
      csr_we    <= 1'b1;
      csr_wdata <= rot;
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow_rot = rot;
      rot_seen[rot] = 1'b1;
   endtask

   function automatic int pick_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return $signed(10'($urandom()));
      if (r < 20) return $urandom_range(0, 60) - 30;
      return $urandom_range(0, 240) - 20;
   endfunction

   function automatic int pick_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return $signed(10'($urandom()));
      if (r < 10) return $urandom_range(0, 400) - 200;
      return $urandom_range(0, 60) - 30;
   endfunction

   function automatic cmd_row_type random_cmd();
      cmd_row_type c;
      int r;
      r = $urandom_range(0, 99);
      c.mode = (r < 15) ? mrf_pkg::MODE_PIXEL : (r < 35) ? mrf_pkg::MODE_HLINE :
               (r < 55) ? mrf_pkg::MODE_VLINE : (r < 87) ? mrf_pkg::MODE_RECT :
               (r < 93) ? mrf_pkg::MODE_FIND : (r < 96) ? mrf_pkg::MODE_CLEAR :
               (r < 98) ? MODE_SPARE_LO : MODE_SPARE_HI;
      c.x_pos    = 10'(pick_coord());
      c.y_pos    = 10'(pick_coord());
      c.span_x   = 10'(pick_span());
      c.span_y   = 10'(pick_span());
      c.ink      = ($urandom_range(0, 2) != 0);
      c.run_from = ($urandom_range(0, 9) == 0) ? 13'($urandom())
                                               : 13'($urandom_range(0, mrf_pkg::StoreBytes - 1));
      c.has_gold = 1'b0;
      c.gold     = '0;
      return c;
   endfunction

   function automatic cmd_row_type row(logic [2:0] m, int x, int y, int sx, int sy, bit ink,
                                       int from, bit g, int cc, bit f, int st, int len);
      cmd_row_type c;
      c.mode = m; c.x_pos = 10'(x); c.y_pos = 10'(y); c.span_x = 10'(sx); c.span_y = 10'(sy);
      c.ink = ink; c.run_from = 13'(from); c.has_gold = g;
      c.gold.changed_count = 13'(cc); c.gold.run_found = f;
      c.gold.run_start = 13'(st); c.gold.run_length = 13'(len);
      return c;
   endfunction

   // Response side: stall pattern and in-order compare
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         case ((cycle_count / 300) % 4)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= ((cycle_count % 7) < 2);
            default: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
         endcase
      end
   end

   always @(negedge clock) begin
      mrf_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with none pending, changed_count",
                            rsp_ch.changed_count, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_ch.changed_count !== want.changed_count)
               report_mismatch("changed_count", rsp_ch.changed_count, want.changed_count);
            if (rsp_ch.run_found !== want.run_found)
               report_mismatch("run_found", rsp_ch.run_found, want.run_found);
            if (rsp_ch.run_start !== want.run_start)
               report_mismatch("run_start", rsp_ch.run_start, want.run_start);
            if (rsp_ch.run_length !== want.run_length)
               report_mismatch("run_length", rsp_ch.run_length, want.run_length);
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending",
                  cycle_count, pending_rsp.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      cmd_row_type dir_rows[$];
      bit [1:0] rot_order[4];
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.mode    = mrf_pkg::MODE_PIXEL;
      req_ch.x_pos   = '0;
      req_ch.y_pos   = '0;
      req_ch.span_x  = '0;
      req_ch.span_y  = '0;
      req_ch.ink     = 1'b0;
      req_ch.run_from = '0;
      rsp_ch.ready   = 1'b0;
      cycle_count    = 0;
      mismatches     = 0;
      rsp_seen       = 0;
      burst_left     = 0;
      rot_seen       = 4'b0001;
      shadow_rot     = 2'd0;
      foreach (mode_hits[k]) mode_hits[k] = 0;
      foreach (shadow_fb[k]) begin
         shadow_fb[k] = '0;
         shadow_dirty[k] = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table: empty store, extremes, clipping, spare modes
      dir_rows = '{
         row(mrf_pkg::MODE_FIND,   0,    0,    0,    0,    0, 0,    1, 0,    0, 0, 0),
         row(mrf_pkg::MODE_PIXEL,  0,    0,    0,    0,    1, 0,    1, 1,    0, 0, 0),
         row(mrf_pkg::MODE_PIXEL,  0,    0,    0,    0,    1, 0,    1, 0,    0, 0, 0),
         row(mrf_pkg::MODE_HLINE,  0,    0,    200,  0,    1, 0,    1, 25,   0, 0, 0),
         row(mrf_pkg::MODE_FIND,   0,    0,    0,    0,    0, 0,    1, 0,    1, 0, 25),
         row(mrf_pkg::MODE_FIND,   0,    0,    0,    0,    0, 25,   1, 0,    0, 0, 0),
         row(mrf_pkg::MODE_FIND,   0,    0,    0,    0,    0, 8191, 1, 0,    0, 0, 0),
         row(mrf_pkg::MODE_CLEAR,  5,    5,    5,    5,    1, 3,    1, 0,    0, 0, 0),
         row(mrf_pkg::MODE_FIND,   0,    0,    0,    0,    0, 0,    1, 0,    0, 0, 0),
         row(mrf_pkg::MODE_PIXEL, -1,    0,    0,    0,    1, 0,    1, 0,    0, 0, 0),
         row(mrf_pkg::MODE_PIXEL,  511,  511,  0,    0,    1, 0,    1, 0,    0, 0, 0),
         row(mrf_pkg::MODE_HLINE,  10,   10,   0,    0,    1, 0,    1, 0,    0, 0, 0),
         row(mrf_pkg::MODE_RECT,  -512, -512, -512, -512,  1, 0,    1, 0,    0, 0, 0),
         row(MODE_SPARE_LO,        3,    3,    9,    9,    1, 0,    1, 0,    0, 0, 0),
         row(MODE_SPARE_HI,       -3,    3,    9,   -9,    1, 4999, 1, 0,    0, 0, 0),
         row(mrf_pkg::MODE_HLINE,  199,  7,   -512,  0,    1, 0,    0, 0,    0, 0, 0),
         row(mrf_pkg::MODE_VLINE,  37,   199,  0,   -1,    1, 0,    0, 0,    0, 0, 0),
         row(mrf_pkg::MODE_VLINE,  3,    0,    0,    511,  1, 0,    0, 0,    0, 0, 0),
         row(mrf_pkg::MODE_RECT,   13,   20,  -9,    17,   1, 0,    0, 0,    0, 0, 0),
         row(mrf_pkg::MODE_FIND,   0,    0,    0,    0,    0, 4999, 0, 0,    0, 0, 0),
         row(mrf_pkg::MODE_RECT,   0,    0,    511,  511,  1, 0,    0, 0,    0, 0, 0),
         row(mrf_pkg::MODE_RECT,   0,    0,    511,  511,  0, 0,    1, 5000, 0, 0, 0),
         row(mrf_pkg::MODE_FIND,   0,    0,    0,    0,    0, 0,    1, 0,    1, 0, 5000),
         row(mrf_pkg::MODE_CLEAR,  0,    0,    0,    0,    0, 0,    1, 0,    0, 0, 0)
      };
      foreach (dir_rows[i]) send_cmd(dir_rows[i]);

      // Random commands under each rotation, extremes first
      rot_order = '{2'd3, 2'd1, 2'd2, 2'd0};
      foreach (rot_order[p]) begin
         write_rotation(rot_order[p]);
         for (int n = 0; n < 207; n++) begin
            if (p == 1 && n == 100) drain_pending();
            send_cmd(random_cmd());
         end
      end

      drain_pending();
      $display("covered %0d responses: pixel %0d, hline %0d, vline %0d, rect %0d,",
               rsp_seen, mode_hits[mrf_pkg::MODE_PIXEL], mode_hits[mrf_pkg::MODE_HLINE],
               mode_hits[mrf_pkg::MODE_VLINE], mode_hits[mrf_pkg::MODE_RECT]);
      $display("find %0d, clear %0d, spare %0d; rotations seen %b",
               mode_hits[mrf_pkg::MODE_FIND], mode_hits[mrf_pkg::MODE_CLEAR],
               mode_hits[MODE_SPARE_LO] + mode_hits[MODE_SPARE_HI], rot_seen);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
